// File: hdl/point_pair_polar_convert_defines.svh
// Assertion macros for the point pair polar converter.
// Each macro is given in full for simulation and as an empty body for synthesis.
`ifndef POINT_PAIR_POLAR_CONVERT_DEFINES_SVH
`define POINT_PAIR_POLAR_CONVERT_DEFINES_SVH

`ifndef SYNTHESIS

// ante holds now -> cons holds in the same cycle
`define PPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppc assertion failed: implication");

// ante holds now -> cons holds after the ##n delay
`define PPC_ASSERT_DLY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("ppc assertion failed: delayed implication");

`else

`define PPC_ASSERT_IMP(label, ante, cons)
`define PPC_ASSERT_DLY(label, ante, n, cons)

`endif

`endif

// File: hdl/ppc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

  // field widths
  localparam int COORD_BITS = 16;
  localparam int ANGLE_BITS = 16;
  localparam int TOL_BITS   = 16;
  localparam int DIST_BITS  = 17;

  // derived widths
  localparam int DIFF_BITS      = COORD_BITS + 1;
  localparam int MAG_BITS       = COORD_BITS;
  localparam int PROD_BITS      = 2 * MAG_BITS;
  localparam int SQ_BITS        = 2 * MAG_BITS + 1;
  localparam int ROOT_BITS      = MAG_BITS + 1;
  localparam int REM_BITS       = 2 * ROOT_BITS;
  localparam int ROOT_IDX_BITS  = $clog2(ROOT_BITS);
  localparam int TOLSQ_BITS     = 2 * TOL_BITS;
  localparam int CMP_BITS       = (SQ_BITS > TOLSQ_BITS) ? SQ_BITS : TOLSQ_BITS;
  localparam int DIST_CALC_BITS = (ROOT_BITS + 1 > DIST_BITS) ? ROOT_BITS + 1 : DIST_BITS;
  localparam int MSB_BITS       = $clog2(MAG_BITS);

  // CORDIC datapath
  localparam int ITERS         = 32;
  localparam int ITER_IDX_BITS = $clog2(ITERS);
  localparam int XY_BITS       = 64;
  localparam int NORM_MSB      = 59;
  localparam int SHAMT_BITS    = $clog2(NORM_MSB + 1);
  localparam int TURN_BITS     = 32;
  localparam int Z_BITS        = TURN_BITS + 2;
  localparam int ANGLE_DROP    = TURN_BITS - ANGLE_BITS;

  // both chains are padded to the longer one
  localparam int CHAIN_DEPTH = (ITERS > ROOT_BITS) ? ITERS : ROOT_BITS;
  localparam int SQRT_PAD    = CHAIN_DEPTH - ROOT_BITS;
  localparam int CORDIC_PAD  = CHAIN_DEPTH - ITERS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic [MAG_BITS-1:0]          mag_t;
  typedef logic [PROD_BITS-1:0]         prod_t;
  typedef logic [SQ_BITS-1:0]           sq_t;
  typedef logic [ROOT_BITS-1:0]         root_t;
  typedef logic [REM_BITS-1:0]          rem_t;
  typedef logic [ROOT_IDX_BITS-1:0]     root_idx_t;
  typedef logic [TOL_BITS-1:0]          tol_t;
  typedef logic [TOLSQ_BITS-1:0]        tolsq_t;
  typedef logic [CMP_BITS-1:0]          cmp_t;
  typedef logic [DIST_CALC_BITS-1:0]    dist_calc_t;
  typedef logic [DIST_BITS-1:0]         dist_t;
  typedef logic [ANGLE_BITS-1:0]        angle_t;
  typedef logic [MSB_BITS-1:0]          msb_t;
  typedef logic [SHAMT_BITS-1:0]        shamt_t;
  typedef logic [ITER_IDX_BITS-1:0]     iter_idx_t;
  typedef logic signed [XY_BITS-1:0]    xy_t;
  typedef logic signed [Z_BITS-1:0]     z_t;
  typedef logic [TURN_BITS-1:0]         turn_t;
  typedef logic [TURN_BITS:0]           turn_ext_t;

  localparam dist_calc_t DIST_MAX     = dist_calc_t'({DIST_BITS{1'b1}});
  localparam turn_t      QUARTER_TURN = turn_t'(1) << (TURN_BITS - 2);
  localparam turn_t      HALF_TURN    = turn_t'(1) << (TURN_BITS - 1);
  localparam z_t         QUARTER_Z    = z_t'(QUARTER_TURN);
  localparam turn_ext_t  ROUND_ADD    = (turn_ext_t'(1) << ANGLE_DROP) >> 1;
  localparam tol_t       TOL_RESET    = tol_t'(1);

  // quadrant code: {dx negative, dy negative}
  typedef enum logic [1:0] {
    QUAD_FIRST  = 2'b00,
    QUAD_FOURTH = 2'b01,
    QUAD_SECOND = 2'b10,
    QUAD_THIRD  = 2'b11
  } quadrant_t;

  typedef struct packed {
    logic negx;
    logic negy;
    logic ax_zero;
    logic ay_zero;
    logic coinc;
  } cordic_meta_t;

  typedef struct packed {
    logic         valid;
    xy_t          x;
    xy_t          y;
    z_t           z;
    cordic_meta_t meta;
  } cordic_lane_t;

  typedef struct packed {
    rem_t  rem;
    root_t root;
  } sqrt_lane_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic turn_t atan_turn(input iter_idx_t idx);
    turn_t v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      5'd31: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ppc_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One vectoring CORDIC micro-rotation, registered.
module ppc_cordic_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ppc_pkg::iter_idx_t   shift,
  input  wire ppc_pkg::cordic_lane_t lane_in,
  output ppc_pkg::cordic_lane_t     lane_out
);

  ppc_pkg::xy_t xs;
  ppc_pkg::xy_t ys;
  ppc_pkg::z_t  step;
  logic         rot_cw;

  // floor shifts
  assign xs     = $signed(lane_in.x) >>> shift;
  assign ys     = $signed(lane_in.y) >>> shift;
  assign step   = ppc_pkg::z_t'(ppc_pkg::atan_turn(shift));
  assign rot_cw = ~lane_in.y[ppc_pkg::XY_BITS-1];

  always_ff @(posedge clk) begin
    lane_out.meta <= lane_in.meta;
    if (rot_cw) begin
      lane_out.x <= lane_in.x + ys;
      lane_out.y <= lane_in.y - xs;
      lane_out.z <= lane_in.z + step;
    end else begin
      lane_out.x <= lane_in.x - ys;
      lane_out.y <= lane_in.y + xs;
      lane_out.z <= lane_in.z - step;
    end
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else begin
      lane_out.valid <= lane_in.valid;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ppc_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One result bit of the restoring square root, registered.
module ppc_sqrt_cell (
  input  wire logic                clk,
  input  wire ppc_pkg::root_idx_t  bit_idx,
  input  wire ppc_pkg::sqrt_lane_t lane_in,
  output ppc_pkg::sqrt_lane_t      lane_out
);

  ppc_pkg::rem_t root_w;
  ppc_pkg::rem_t trial;
  logic          fits;

  // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
  assign root_w = ppc_pkg::rem_t'(lane_in.root);
  assign trial  = ((root_w << bit_idx) << 1)
                | ((ppc_pkg::rem_t'(1) << bit_idx) << bit_idx);
  assign fits   = lane_in.rem >= trial;

  always_ff @(posedge clk) begin
    lane_out.rem  <= fits ? lane_in.rem - trial : lane_in.rem;
    lane_out.root <= fits ? (lane_in.root | (ppc_pkg::root_t'(1) << bit_idx))
                          : lane_in.root;
  end

endmodule

`default_nettype wire

// File: hdl/point_pair_polar_convert.sv
`timescale 1ns / 1ps
`default_nettype none

// Polar form of the vector between two points. A transaction is taken on
// every clock edge with start high and busy low; busy is only high during
// reset, so a new point pair may follow in every cycle. The result (rounded
// distance, 16-bit binary angle, coincidence flag) appears on the result
// ports for exactly one cycle with done high; the receiver cannot stall it,
// so it must take every strobe. The path runs through three front-end
// stages, the 32-cell CORDIC chain (one micro-rotation per cell) and the
// output register; the 17-cell square root chain runs beside it and is
// padded to match. The tolerance register may be written at any time the
// pipe is empty.

`include "point_pair_polar_convert_defines.svh"

module point_pair_polar_convert (
  input  wire logic             clk,
  input  wire logic             rst,
  // command side
  input  wire logic             start,
  output logic                  busy,
  input  wire ppc_pkg::coord_t  from_x,
  input  wire ppc_pkg::coord_t  from_y,
  input  wire ppc_pkg::coord_t  to_x,
  input  wire ppc_pkg::coord_t  to_y,
  // tolerance register
  input  wire logic             cfg_we,
  input  wire ppc_pkg::tol_t    cfg_data,
  // result side
  output logic                  done,
  output ppc_pkg::dist_t        distance,
  output ppc_pkg::angle_t       direction,
  output logic                  coincident
);

  // cycles from the accepting edge to the sampled strobe
  localparam int LATENCY = ppc_pkg::CHAIN_DEPTH + 4;

  // ---------------------------------------------------------------
  // tolerance register and its square (unenforced: change only while idle)
  // ---------------------------------------------------------------
  ppc_pkg::tol_t   tol;
  ppc_pkg::tolsq_t tol_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol    <= ppc_pkg::TOL_RESET;
      tol_sq <= ppc_pkg::tolsq_t'(ppc_pkg::TOL_RESET);
    end else begin
      if (cfg_we) begin
        tol <= cfg_data;
      end
      tol_sq <= ppc_pkg::tolsq_t'(tol) * ppc_pkg::tolsq_t'(tol);
    end
  end

  // the pipe never stalls; hold off only while in reset
  assign busy = rst;

  // ---------------------------------------------------------------
  // stage 1: difference vector
  // ---------------------------------------------------------------
  logic           v1;
  ppc_pkg::diff_t dx1;
  ppc_pkg::diff_t dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    dx1 <= ppc_pkg::diff_t'(to_x) - ppc_pkg::diff_t'(from_x);
    dy1 <= ppc_pkg::diff_t'(to_y) - ppc_pkg::diff_t'(from_y);
  end

  // ---------------------------------------------------------------
  // stage 2: magnitudes, signs, squares
  // ---------------------------------------------------------------
  ppc_pkg::diff_t abs_x;
  ppc_pkg::diff_t abs_y;
  ppc_pkg::mag_t  ax_c;
  ppc_pkg::mag_t  ay_c;

  assign abs_x = dx1[ppc_pkg::DIFF_BITS-1] ? -dx1 : dx1;
  assign abs_y = dy1[ppc_pkg::DIFF_BITS-1] ? -dy1 : dy1;
  assign ax_c  = abs_x[ppc_pkg::MAG_BITS-1:0];
  assign ay_c  = abs_y[ppc_pkg::MAG_BITS-1:0];

  logic           v2;
  logic           negx2;
  logic           negy2;
  ppc_pkg::mag_t  ax2;
  ppc_pkg::mag_t  ay2;
  ppc_pkg::prod_t sqx2;
  ppc_pkg::prod_t sqy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    negx2 <= dx1[ppc_pkg::DIFF_BITS-1];
    negy2 <= dy1[ppc_pkg::DIFF_BITS-1];
    ax2   <= ax_c;
    ay2   <= ay_c;
    sqx2  <= ppc_pkg::prod_t'(ax_c) * ppc_pkg::prod_t'(ax_c);
    sqy2  <= ppc_pkg::prod_t'(ay_c) * ppc_pkg::prod_t'(ay_c);
  end

  // ---------------------------------------------------------------
  // stage 3: sum of squares, coincidence test, leading one of max
  // ---------------------------------------------------------------
  ppc_pkg::sq_t  sum_c;
  ppc_pkg::mag_t max_c;
  ppc_pkg::msb_t msb_c;

  assign sum_c = ppc_pkg::sq_t'(sqx2) + ppc_pkg::sq_t'(sqy2);
  assign max_c = (ax2 > ay2) ? ax2 : ay2;

  always_comb begin
    msb_c = '0;
    for (int i = 0; i < ppc_pkg::MAG_BITS; i++) begin
      if (max_c[i]) begin
        msb_c = ppc_pkg::msb_t'(i);
      end
    end
  end

  logic                  v3;
  ppc_pkg::sq_t          s3;
  ppc_pkg::mag_t         ax3;
  ppc_pkg::mag_t         ay3;
  ppc_pkg::msb_t         msb3;
  ppc_pkg::cordic_meta_t meta3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3            <= sum_c;
    ax3           <= ax2;
    ay3           <= ay2;
    msb3          <= msb_c;
    meta3.negx    <= negx2;
    meta3.negy    <= negy2;
    meta3.ax_zero <= (ax2 == '0);
    meta3.ay_zero <= (ay2 == '0);
    // strictly below tolerance, compared on squares
    meta3.coinc   <= ppc_pkg::cmp_t'(sum_c) < ppc_pkg::cmp_t'(tol_sq);
  end

  // ---------------------------------------------------------------
  // CORDIC chain: normalise so the larger magnitude has its top bit
  // at the fixed position, then one micro-rotation per cell
  // ---------------------------------------------------------------
  ppc_pkg::shamt_t       shamt;
  ppc_pkg::cordic_lane_t cordic_chain [ppc_pkg::ITERS+1];

  assign shamt = ppc_pkg::shamt_t'(ppc_pkg::NORM_MSB) - ppc_pkg::shamt_t'(msb3);

  assign cordic_chain[0] = '{
    valid: v3,
    x:     ppc_pkg::xy_t'(ax3) << shamt,
    y:     ppc_pkg::xy_t'(ay3) << shamt,
    z:     '0,
    meta:  meta3
  };

  for (genvar g = 0; g < ppc_pkg::ITERS; g++) begin : g_cordic
    ppc_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (ppc_pkg::iter_idx_t'(g)),
      .lane_in  (cordic_chain[g]),
      .lane_out (cordic_chain[g+1])
    );
  end

  // pad so both chains land together
  ppc_pkg::cordic_lane_t cordic_pad [ppc_pkg::CORDIC_PAD+1];
  assign cordic_pad[0] = cordic_chain[ppc_pkg::ITERS];

  for (genvar p = 0; p < ppc_pkg::CORDIC_PAD; p++) begin : g_cordic_pad
    always_ff @(posedge clk) begin
      if (rst) begin
        cordic_pad[p+1] <= '0;
      end else begin
        cordic_pad[p+1] <= cordic_pad[p];
      end
    end
  end

  // ---------------------------------------------------------------
  // square root chain: one result bit per cell, MSB first
  // ---------------------------------------------------------------
  ppc_pkg::sqrt_lane_t sqrt_chain [ppc_pkg::ROOT_BITS+1];

  assign sqrt_chain[0] = '{rem: ppc_pkg::rem_t'(s3), root: '0};

  for (genvar g = 0; g < ppc_pkg::ROOT_BITS; g++) begin : g_sqrt
    ppc_sqrt_cell u_cell (
      .clk      (clk),
      .bit_idx  (ppc_pkg::root_idx_t'(ppc_pkg::ROOT_BITS - 1 - g)),
      .lane_in  (sqrt_chain[g]),
      .lane_out (sqrt_chain[g+1])
    );
  end

  ppc_pkg::sqrt_lane_t sqrt_pad [ppc_pkg::SQRT_PAD+1];
  assign sqrt_pad[0] = sqrt_chain[ppc_pkg::ROOT_BITS];

  for (genvar p = 0; p < ppc_pkg::SQRT_PAD; p++) begin : g_sqrt_pad
    always_ff @(posedge clk) begin
      sqrt_pad[p+1] <= sqrt_pad[p];
    end
  end

  // ---------------------------------------------------------------
  // output stage: clamp, fold into full turn, round, distance round
  // ---------------------------------------------------------------
  ppc_pkg::cordic_lane_t lane_f;
  ppc_pkg::sqrt_lane_t   sq_f;

  assign lane_f = cordic_pad[ppc_pkg::CORDIC_PAD];
  assign sq_f   = sqrt_pad[ppc_pkg::SQRT_PAD];

  ppc_pkg::turn_t     t_c;
  ppc_pkg::turn_t     fold_c;
  ppc_pkg::turn_ext_t rounded_c;
  ppc_pkg::angle_t    dir_c;
  ppc_pkg::dist_calc_t dist_w;
  ppc_pkg::dist_t     dist_c;

  always_comb begin
    // first quadrant angle; axis cases are exact
    if (lane_f.meta.ay_zero) begin
      t_c = '0;
    end else if (lane_f.meta.ax_zero) begin
      t_c = ppc_pkg::QUARTER_TURN;
    end else if (lane_f.z < 0) begin
      t_c = '0;
    end else if (lane_f.z > ppc_pkg::QUARTER_Z) begin
      t_c = ppc_pkg::QUARTER_TURN;
    end else begin
      t_c = lane_f.z[ppc_pkg::TURN_BITS-1:0];
    end

    fold_c = t_c;
    case (ppc_pkg::quadrant_t'({lane_f.meta.negx, lane_f.meta.negy}))
      ppc_pkg::QUAD_FIRST:  fold_c = t_c;
      ppc_pkg::QUAD_SECOND: fold_c = ppc_pkg::HALF_TURN - t_c;
      ppc_pkg::QUAD_THIRD:  fold_c = ppc_pkg::HALF_TURN + t_c;
      ppc_pkg::QUAD_FOURTH: fold_c = '0 - t_c;
    endcase

    // round half up, wraps at a full turn
    rounded_c = {1'b0, fold_c} + ppc_pkg::ROUND_ADD;
    dir_c     = rounded_c[ppc_pkg::ANGLE_DROP +: ppc_pkg::ANGLE_BITS];
    if (lane_f.meta.coinc || (lane_f.meta.ax_zero && lane_f.meta.ay_zero)) begin
      dir_c = '0;
    end

    // remainder above the root means s > r*(r+1): round up
    dist_w = ppc_pkg::dist_calc_t'(sq_f.root)
           + ppc_pkg::dist_calc_t'(sq_f.rem > ppc_pkg::rem_t'(sq_f.root));
    if (dist_w > ppc_pkg::DIST_MAX) begin
      dist_c = ppc_pkg::DIST_MAX[ppc_pkg::DIST_BITS-1:0];
    end else begin
      dist_c = dist_w[ppc_pkg::DIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lane_f.valid;
    end
    distance   <= dist_c;
    direction  <= dir_c;
    coincident <= lane_f.meta.coinc;
  end

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  // every accepted transaction returns exactly after the pipe depth
  `PPC_ASSERT_DLY(a_result_follows, start && !busy, LATENCY, done)
  // no strobe without a transaction taken the pipe depth before
  `PPC_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, LATENCY))
  // coinciding points never report an angle
  `PPC_ASSERT_IMP(a_coinc_dir_zero, done && coincident, direction == '0)

endmodule

`default_nettype wire

// File: bench/point_pair_polar_convert_tb.sv
`timescale 1ns / 1ps

// Bench for the point pair polar converter.
// Point pairs go in as command transactions (start/busy). Results come back
// one per transaction, strobed by done, and cannot be held off. Each accepted
// transaction is run through a local model of the block (exact root for the
// distance, 32-step vectoring CORDIC for the angle, quadrant fold and
// rounding) and the prediction is queued. Every strobed result is checked
// field by field against the oldest queued prediction.

module point_pair_polar_convert_tb;

  localparam int  PIPE_LATENCY = 35;           // accepting edge to done strobe
  localparam time TIMEOUT_NS   = 2_000_000;    // far beyond the slowest legal run

  typedef longint unsigned u64_t;

  // binary angle in units of 2^-32 turn
  localparam longint unsigned QUARTER_TURN = 64'd1 << 30;
  localparam longint unsigned HALF_TURN    = 64'd1 << 31;
  localparam longint unsigned FULL_TURN    = 64'd1 << 32;
  localparam longint unsigned DIST_CEIL    = 64'h1_FFFF;

  // one predicted result, with the pair that caused it kept for messages
  typedef struct {
    ppc_pkg::coord_t fx;
    ppc_pkg::coord_t fy;
    ppc_pkg::coord_t tx;
    ppc_pkg::coord_t ty;
    ppc_pkg::dist_t  length;
    ppc_pkg::angle_t dir;
    logic            coinc;
  } polar_result_t;

  // atan(2^-i), rounded to 2^-32 turn
  longint unsigned atan_step [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  // every DUT input known from time zero
  logic            clk      = 1'b0;
  logic            rst      = 1'b1;
  logic            start    = 1'b0;
  ppc_pkg::coord_t from_x   = '0;
  ppc_pkg::coord_t from_y   = '0;
  ppc_pkg::coord_t to_x     = '0;
  ppc_pkg::coord_t to_y     = '0;
  logic            cfg_we   = 1'b0;
  ppc_pkg::tol_t   cfg_data = '0;

  logic            busy;
  logic            done;
  ppc_pkg::dist_t  distance;
  ppc_pkg::angle_t direction;
  logic            coincident;

  // model copy of the tolerance register
  ppc_pkg::tol_t tol_now = ppc_pkg::TOL_RESET;

  polar_result_t polar_pending[$];
  int            mismatch_count = 0;

  point_pair_polar_convert u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .from_x     (from_x),
    .from_y     (from_y),
    .to_x       (to_x),
    .to_y       (to_y),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .done       (done),
    .distance   (distance),
    .direction  (direction),
    .coincident (coincident)
  );

  always #2 clk = ~clk;

  // Hard stop, in case the pipe hangs or a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // ------------------------------------------------------------------
  // Model
  // ------------------------------------------------------------------

  // First-quadrant angle of (ax, ay) by vectoring CORDIC. The larger
  // magnitude is normalised so its top bit sits at bit 59; shifts floor.
  function automatic longint unsigned quadrant_angle(longint unsigned ax,
                                                     longint unsigned ay);
    longint          x, y, z, xs, ys;
    longint unsigned m;
    int              msb, i;
    if (ay == 0) return 0;
    if (ax == 0) return QUARTER_TURN;
    m   = (ax > ay) ? ax : ay;
    msb = 0;
    while (m > 1) begin
      m = m >> 1;
      msb++;
    end
    x = longint'(ax << (59 - msb));
    y = longint'(ay << (59 - msb));
    z = 0;
    for (i = 0; i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_step[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_step[i]);
      end
    end
    // accumulated rounding can stray just outside the quadrant
    if (z < 0) z = 0;
    if (u64_t'(z) > QUARTER_TURN) z = longint'(QUARTER_TURN);
    return u64_t'(z);
  endfunction

  function automatic polar_result_t predict_polar(ppc_pkg::coord_t fx, ppc_pkg::coord_t fy,
                                                  ppc_pkg::coord_t tx, ppc_pkg::coord_t ty,
                                                  ppc_pkg::tol_t tol);
    polar_result_t      r;
    longint             dx, dy;
    longint unsigned    ax, ay, sumsq, tolsq, root, c, t, turn;
    int                 b;
    ppc_pkg::quadrant_t quad;
    r.fx  = fx;
    r.fy  = fy;
    r.tx  = tx;
    r.ty  = ty;
    dx    = longint'(tx) - longint'(fx);
    dy    = longint'(ty) - longint'(fy);
    ax    = (dx < 0) ? u64_t'(-dx) : u64_t'(dx);
    ay    = (dy < 0) ? u64_t'(-dy) : u64_t'(dy);
    sumsq = ax * ax + ay * ay;

    // bitwise integer root; the root never exceeds 17 bits here
    root = 0;
    for (b = 17; b >= 0; b--) begin
      c = root | (64'd1 << b);
      if (c * c <= sumsq) root = c;
    end
    // round to nearest: no ties are possible for integer sums
    if (sumsq > root * (root + 1)) root++;
    if (root > DIST_CEIL) root = DIST_CEIL;
    r.length = ppc_pkg::dist_t'(root);

    // coincidence compared in the squared domain, no root involved
    tolsq   = u64_t'(tol) * u64_t'(tol);
    r.coinc = (tolsq > sumsq);

    turn = 0;
    if (!r.coinc && sumsq != 0) begin
      t    = quadrant_angle(ax, ay);
      quad = ppc_pkg::quadrant_t'({dx < 0, dy < 0});
      case (quad)
        ppc_pkg::QUAD_SECOND: turn = HALF_TURN - t;
        ppc_pkg::QUAD_THIRD:  turn = HALF_TURN + t;
        ppc_pkg::QUAD_FOURTH: turn = FULL_TURN - t;
        default:              turn = t;
      endcase
      turn = turn & (FULL_TURN - 1);
      // half-up rounding to the output width, wrapping at a full turn
      turn = (turn + (64'd1 << (ppc_pkg::ANGLE_DROP - 1))) >> ppc_pkg::ANGLE_DROP;
    end
    r.dir = ppc_pkg::angle_t'(turn);
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Outputs are read in the active region just after the edge, so they
  // still hold the values of the cycle the edge closes.
  always @(posedge clk) begin : check_results
    polar_result_t head;
    if (!rst && done !== 1'b0) begin
      if (polar_pending.size() == 0) begin
        report_mismatch($sformatf("result d=%0d a=%0d c=%0b with nothing outstanding",
                                  distance, direction, coincident));
      end else begin
        head = polar_pending.pop_front();
        if (distance !== head.length)
          report_mismatch($sformatf("(%0d,%0d)->(%0d,%0d) distance %0d, want %0d",
                                    head.fx, head.fy, head.tx, head.ty,
                                    distance, head.length));
        if (direction !== head.dir)
          report_mismatch($sformatf("(%0d,%0d)->(%0d,%0d) direction %0d, want %0d",
                                    head.fx, head.fy, head.tx, head.ty,
                                    direction, head.dir));
        if (coincident !== head.coinc)
          report_mismatch($sformatf("(%0d,%0d)->(%0d,%0d) coincident %0b, want %0b",
                                    head.fx, head.fy, head.tx, head.ty,
                                    coincident, head.coinc));
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // Present one pair and hold it until the transaction is taken. Returns in
  // the step of the accepting edge with start still high, so a following
  // call keeps the strobe up without a dip.
  task automatic send_pair(ppc_pkg::coord_t fx, ppc_pkg::coord_t fy,
                           ppc_pkg::coord_t tx, ppc_pkg::coord_t ty);
    start  <= 1'b1;
    from_x <= fx;
    from_y <= fy;
    to_x   <= tx;
    to_y   <= ty;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    polar_pending.push_back(predict_polar(fx, fy, tx, ty, tol_now));
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 9)) @(posedge clk);
  endtask

  // Every transaction yields a result, so an empty queue means an empty pipe.
  task automatic drain_pipe();
    start <= 1'b0;
    while (polar_pending.size() != 0) @(posedge clk);
  endtask

  task automatic set_tolerance(ppc_pkg::tol_t value);
    drain_pipe();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= ppc_pkg::tol_t'($urandom);
    tol_now  = value;
  endtask

  // base +/- offset, kept inside the coordinate range
  function automatic ppc_pkg::coord_t offset_coord(ppc_pkg::coord_t base, int offset);
    int v;
    v = int'(base) + offset;
    if (v > 32767 || v < -32768) v = int'(base) - offset;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return ppc_pkg::coord_t'(v);
  endfunction

  function automatic ppc_pkg::coord_t corner_coord();
    case ($urandom_range(0, 4))
      0:       return ppc_pkg::coord_t'(-32768);
      1:       return ppc_pkg::coord_t'(-1);
      2:       return ppc_pkg::coord_t'(0);
      3:       return ppc_pkg::coord_t'(1);
      default: return ppc_pkg::coord_t'(32767);
    endcase
  endfunction

  // Random pair, full-range in four draws of ten, with a share of short vectors
  // around the tolerance, axis-aligned and diagonal vectors, corners and repeats.
  task automatic random_pair(output ppc_pkg::coord_t fx, output ppc_pkg::coord_t fy,
                             output ppc_pkg::coord_t tx, output ppc_pkg::coord_t ty);
    int span, mag;
    fx   = ppc_pkg::coord_t'($urandom);
    fy   = ppc_pkg::coord_t'($urandom);
    tx   = ppc_pkg::coord_t'($urandom);
    ty   = ppc_pkg::coord_t'($urandom);
    span = int'(tol_now) + int'(tol_now) / 2 + 4;
    case ($urandom_range(0, 9))
      4, 5: begin
        // near the coincidence boundary
        tx = offset_coord(fx, int'($urandom_range(0, span)) - span / 2);
        ty = offset_coord(fy, int'($urandom_range(0, span)) - span / 2);
      end
      6: begin
        if ($urandom_range(0, 1)) ty = fy;
        else tx = fx;
      end
      7: begin
        fx = corner_coord();
        fy = corner_coord();
        tx = corner_coord();
        ty = corner_coord();
      end
      8: begin
        tx = fx;
        ty = fy;
      end
      9: begin
        mag = int'($urandom_range(1, 65535));
        tx  = offset_coord(fx, $urandom_range(0, 1) ? mag : -mag);
        ty  = offset_coord(fy, $urandom_range(0, 1) ? mag : -mag);
      end
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Field extremes, all four quadrants, the axes, wrap of the angle and
  // the zero vector under the reset tolerance.
  task automatic test_directed_extremes();
    send_pair(0, 0, 0, 0);                         // zero vector -> coincident
    send_pair(-32768, -32768, 32767, 32767);       // longest vector, first quadrant
    send_pair(32767, 32767, -32768, -32768);       // third quadrant
    send_pair(32767, -32768, -32768, 32767);       // second quadrant
    send_pair(-32768, 32767, 32767, -32768);       // fourth quadrant
    send_pair(0, 0, 32767, 0);                     // +X axis
    send_pair(32767, 0, -32768, 0);                // -X axis, half turn
    send_pair(0, -32768, 0, 32767);                // +Y axis
    send_pair(0, 32767, 0, -32768);                // -Y axis
    send_pair(5, 5, 6, 5);                         // distance 1, just clear
    send_pair(100, -100, 101, -99);                // short diagonal
    send_pair(0, 0, 32767, -1);                    // rounds up to a full turn -> 0
    send_pair(1, 1, 0, 0);
    send_pair(-1, -1, -1, -1);
    send_pair(12345, -23456, -31000, 30000);
    send_pair(-32768, -32768, -32767, 32767);      // steep, dx = 1
  endtask

  // Zero tolerance, exact boundary and the largest tolerance.
  task automatic test_tolerance_extremes();
    set_tolerance('0);
    send_pair(7, -7, 7, -7);                       // zero vector, not coincident
    send_pair(0, 0, 1, 0);
    set_tolerance(ppc_pkg::tol_t'(5));
    send_pair(0, 0, 3, 4);                         // distance equals tolerance
    send_pair(0, 0, 3, 3);                         // just inside
    send_pair(0, 0, -4, -2);
    set_tolerance('1);
    send_pair(-32768, 0, 32767, 0);                // equals tolerance
    send_pair(-32768, 0, 32766, 0);                // one short -> coincident
    send_pair(-32768, -32768, 32767, 32767);
    set_tolerance(ppc_pkg::TOL_RESET);
  endtask

  // Random phases over a spread of tolerances, with idle bursts on the
  // command side in most phases and none in a couple.
  task automatic test_random_pairs();
    ppc_pkg::coord_t fx, fy, tx, ty;
    ppc_pkg::tol_t   phase_tol;
    bit              allow_idle;
    int              phase, n;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       phase_tol = ppc_pkg::tol_t'($urandom_range(1, 64));
        1:       phase_tol = '0;
        2:       phase_tol = '1;
        3:       phase_tol = ppc_pkg::tol_t'($urandom);
        4:       phase_tol = ppc_pkg::tol_t'($urandom_range(1, 2000));
        default: phase_tol = ppc_pkg::TOL_RESET;
      endcase
      set_tolerance(phase_tol);
      allow_idle = (phase != 2 && phase != 4);
      for (n = 0; n < 140; n++) begin
        random_pair(fx, fy, tx, ty);
        send_pair(fx, fy, tx, ty);
        if (allow_idle && $urandom_range(0, 3) == 0) idle_burst();
      end
    end
  endtask

  // Closing stretch: a transaction on every edge, no idling at all.
  task automatic test_back_to_back();
    ppc_pkg::coord_t fx, fy, tx, ty;
    int              n;
    set_tolerance(ppc_pkg::tol_t'($urandom_range(0, 300)));
    for (n = 0; n < 110; n++) begin
      random_pair(fx, fy, tx, ty);
      send_pair(fx, fy, tx, ty);
    end
  endtask

  task automatic finish_run();
    int waited;
    start  <= 1'b0;
    waited = 0;
    while (polar_pending.size() != 0 && waited < 20 * PIPE_LATENCY) begin
      @(posedge clk);
      waited++;
    end
    // let any stray strobe behind the last result show up
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (polar_pending.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", polar_pending.size()));
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_tolerance_extremes();
    test_random_pairs();
    test_back_to_back();
    finish_run();
  end

endmodule
